### hdl/shtp_pkg.sv
// Shared types and constants of the SPI transfer sequencer.
`timescale 1ns / 1ps

package shtp_pkg;

   // Bytes in the packet header that precedes every received body.
   localparam int unsigned HEADER_BYTES = 4;

   // Width of the packet length carried in the first two received bytes.
   localparam int unsigned PKT_LEN_BITS = 15;

   localparam int unsigned WRITE_LEN_BITS = 9;
   localparam int unsigned XFER_LEN_BITS  = 10;
   localparam int unsigned OFFSET_BITS    = 3;
   localparam int unsigned PHASE_BITS     = 2;

   typedef struct packed {
      logic                      int_asserted;
      logic                      spi_complete;
      logic                      rx_free;
      logic [WRITE_LEN_BITS-1:0] write_len;
      logic [7:0]                rx_len_lo;
      logic [7:0]                rx_len_hi;
   } req_payload_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]    phase;
      logic                     cs_active;
      logic                     start_transfer;
      logic [XFER_LEN_BITS-1:0] transfer_len;
      logic [OFFSET_BITS-1:0]   buffer_offset;
      logic                     wake_pulse;
      logic                     notify_reader;
      logic [XFER_LEN_BITS-1:0] readable_len;
      logic                     write_accepted;
   } rsp_payload_type;

endpackage

### hdl/shtp_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
`timescale 1ns / 1ps

interface shtp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/shtp_spi_transfer_sequencer.sv
// Host-side SPI transfer sequencer: write/header/body phase machine and length tracking.
`timescale 1ns / 1ps

// One request transfer describes one wakeup (interrupt level, SPI completion, buffer
// release, optional write length and the two received length bytes); the block answers
// each with exactly one response transfer describing the phase, chip select, any SPI
// transfer it launches and the byte count ready for the reader. A request is taken into
// an input register and evaluated in the next cycle, and its response is then presented
// from the result register. The block takes a new request every cycle; the result
// register decouples the two sides, and only a stalled response that also holds a
// request in the input register stops further requests.
module shtp_spi_transfer_sequencer #(
   parameter int unsigned RX_BUF_BYTES   = 512,
   parameter int unsigned TX_MAX_PAYLOAD = 256
) (
   input logic clock,
   input logic reset,
   shtp_stream_if.sink   req_stream,
   shtp_stream_if.source rsp_stream
);
   import shtp_pkg::*;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE  = 2'd0,
      PH_WRITE = 2'd1,
      PH_HDR   = 2'd2,
      PH_BODY  = 2'd3
   } phase_state_type;

   localparam logic [PKT_LEN_BITS-1:0] HDR_LEN  = PKT_LEN_BITS'(HEADER_BYTES);
   localparam logic [PKT_LEN_BITS-1:0] BUF_LEN  = PKT_LEN_BITS'(RX_BUF_BYTES);

   // Input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // Sequencer state
   phase_state_type           phase_ff, phase_in;
   logic [WRITE_LEN_BITS-1:0] pending_ff, pending_in;
   logic [PKT_LEN_BITS-1:0]   packet_len_ff, packet_len_in;
   logic [PKT_LEN_BITS-1:0]   ready_len_ff, ready_len_in;
   logic                      cs_low_ff, cs_low_in;

   // Result register
   logic            out_valid_ff;
   rsp_payload_type out_data_ff, out_data_in;

   logic advance;
   logic take_req;
   logic write_ok;
   logic [WRITE_LEN_BITS-1:0] pending_pre;
   logic [PKT_LEN_BITS-1:0] rx_len;
   logic [PKT_LEN_BITS-1:0] got_len;
   logic [PKT_LEN_BITS-1:0] pending_ext;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_stream.ready);
   assign req_stream.ready = !in_valid_ff || advance;
   assign take_req = req_stream.valid && req_stream.ready;

   assign rsp_stream.valid   = out_valid_ff;
   assign rsp_stream.payload = out_data_ff;

   // The continuation flag in the top bit of the high byte is dropped.
   assign rx_len = {in_data_ff.rx_len_hi[6:0], in_data_ff.rx_len_lo};

   assign write_ok = (in_data_ff.write_len != '0)
                  && (32'(in_data_ff.write_len) <= 32'(TX_MAX_PAYLOAD))
                  && (pending_ff == '0);

   assign pending_pre = write_ok ? in_data_ff.write_len : pending_ff;
   assign pending_ext = PKT_LEN_BITS'(pending_pre);
   assign got_len     = (rx_len < pending_ext) ? rx_len : pending_ext;

   always_comb begin
      logic [PKT_LEN_BITS-1:0]   ready_pre;

      ready_pre = in_data_ff.rx_free ? '0 : ready_len_ff;

      phase_in      = phase_ff;
      pending_in    = pending_pre;
      packet_len_in = packet_len_ff;
      ready_len_in  = ready_pre;
      cs_low_in     = cs_low_ff;

      out_data_in                = '0;
      out_data_in.write_accepted = write_ok;

      case (phase_ff)
         PH_IDLE: begin
            if (in_data_ff.int_asserted && ready_pre == '0) begin
               cs_low_in                  = 1'b1;
               out_data_in.start_transfer = 1'b1;
               if (pending_pre != '0) begin
                  phase_in                 = PH_WRITE;
                  out_data_in.transfer_len = XFER_LEN_BITS'(pending_pre);
                  out_data_in.wake_pulse   = 1'b1;
               end else begin
                  phase_in                 = PH_HDR;
                  out_data_in.transfer_len = XFER_LEN_BITS'(HEADER_BYTES);
               end
            end
         end
         PH_WRITE: begin
            if (in_data_ff.spi_complete) begin
               // The device may send less than was written; only the overlap is readable.
               phase_in                  = PH_IDLE;
               cs_low_in                 = 1'b0;
               ready_len_in              = got_len;
               pending_in                = '0;
               out_data_in.notify_reader = (got_len != '0);
            end
         end
         PH_HDR: begin
            if (in_data_ff.spi_complete) begin
               packet_len_in = rx_len;
               if (rx_len > HDR_LEN && rx_len <= BUF_LEN) begin
                  // Chip select stays low across header and body.
                  phase_in                   = PH_BODY;
                  out_data_in.start_transfer = 1'b1;
                  out_data_in.transfer_len   = XFER_LEN_BITS'(rx_len - HDR_LEN);
                  out_data_in.buffer_offset  = OFFSET_BITS'(HEADER_BYTES);
               end else begin
                  phase_in  = PH_IDLE;
                  cs_low_in = 1'b0;
                  if (rx_len == HDR_LEN) begin
                     ready_len_in              = HDR_LEN;
                     out_data_in.notify_reader = 1'b1;
                  end
               end
            end
         end
         PH_BODY: begin
            if (in_data_ff.spi_complete) begin
               phase_in                  = PH_IDLE;
               cs_low_in                 = 1'b0;
               ready_len_in              = packet_len_ff;
               out_data_in.notify_reader = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      out_data_in.phase        = PHASE_BITS'(phase_in);
      out_data_in.cs_active    = cs_low_in;
      out_data_in.readable_len = XFER_LEN_BITS'(ready_len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         pending_ff    <= '0;
         packet_len_ff <= '0;
         ready_len_ff  <= '0;
         cs_low_ff     <= 1'b0;
      end else begin
         if (take_req) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_stream.payload;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= out_data_in;
            phase_ff      <= phase_in;
            pending_ff    <= pending_in;
            packet_len_ff <= packet_len_in;
            ready_len_ff  <= ready_len_in;
            cs_low_ff     <= cs_low_in;
         end else if (rsp_stream.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // A launched transfer always runs with chip select low.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.start_transfer |-> out_data_ff.cs_active)
      else $error("transfer launched with chip select released");

   // Chip select is only held while the machine is away from idle.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !cs_low_ff)
      else $error("chip select low in idle phase");

   // A write phase always has a pending write behind it.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WRITE |-> pending_ff != '0)
      else $error("write phase without a pending write");

   // The reader is only notified of a nonzero byte count.
   assert property (@(posedge clock) disable iff (reset)
      advance && out_data_in.notify_reader |=> ready_len_ff != '0)
      else $error("reader notified with nothing to read");

   // The wake pin is only raised when a write transfer starts.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.wake_pulse
         |-> out_data_ff.start_transfer && out_data_ff.phase == PHASE_BITS'(PH_WRITE))
      else $error("wake pulse outside a write start");

endmodule
